>>> design/kspc_pkg.sv
// ----------------------------------------------------------------------------
// kspc_pkg
// Shared types and constants for the keyboard scan port controller.
// ----------------------------------------------------------------------------
package kspc_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_CW    = $clog2(RING_DEPTH + 1);

    // item modes
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    // port offsets from the base address
    localparam logic [1:0] PORT_A = 2'd0;
    localparam logic [1:0] PORT_B = 2'd1;
    localparam logic [1:0] PORT_C = 2'd2;

    // configuration register indexes
    localparam logic CFG_ORIG_PC = 1'b0;
    localparam logic CFG_VIDEO   = 1'b1;

    // video kinds
    localparam logic [1:0] VIDEO_EGA  = 2'd0;
    localparam logic [1:0] VIDEO_MONO = 2'd1;
    localparam logic [1:0] VIDEO_CGA  = 2'd2;

    localparam logic [7:0] SELF_TEST_CODE = 8'hAA;
    localparam logic [7:0] UNKNOWN_READ   = 8'hFF;
    localparam logic [7:0] SW_A_EGA       = 8'h4D;
    localparam logic [7:0] SW_A_MONO      = 8'h7D;
    localparam logic [7:0] SW_A_CGA       = 8'h6D;
    localparam logic [7:0] SW_C_EGA       = 8'h04;
    localparam logic [7:0] SW_C_MONO      = 8'h07;
    localparam logic [7:0] SW_C_CGA       = 8'h06;
    localparam logic [7:0] SW_C_DEFAULT   = 8'h0D;
    localparam logic [7:0] SW_C_ORIG_HI   = 8'h02;
    localparam logic [7:0] SW_C_ORIG_LO   = 8'h01;
    localparam logic [7:0] TIMER_OUT_BIT  = 8'h20;

    // port B bit positions
    localparam int PB_GATE   = 0;
    localparam int PB_SPKEN  = 1;
    localparam int PB_SWSEL  = 2;
    localparam int PB_SWHI   = 3;
    localparam int PB_FLUSH  = 6;
    localparam int PB_ACK    = 7;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] port_offset;
        logic [7:0] data_byte;
        logic       speaker_timer_out;
    } t_kspc_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       speaker_gate;
        logic       spk_data_en;
        logic       speaker_ever_enabled;
    } t_kspc_out;

    typedef struct packed {
        logic       push;
        logic       flush;
        logic       pop;
        logic [7:0] data;
    } t_kspc_ring_ctl;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } t_kspc_ring_sts;

endpackage

>>> design/keyboard_scan_port_controller.sv
// ----------------------------------------------------------------------------
// keyboard_scan_port_controller
// Keyboard port block: scan code ring, port A/B/C reads, port B control.
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     i_start, o_busy, i_in                  start high, busy low
//  result    o_valid, o_result                      one-cycle strobe
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata       write enable
//
// One word is taken every cycle; busy stays low. The result of a word passes
// through the input register, then through the port logic into the result
// register. Reset is synchronous, active low; it clears the ring pointers and
// the latches and returns the configuration to its defaults. Results cannot
// be stalled, so none are ever held back.
// ----------------------------------------------------------------------------
module keyboard_scan_port_controller import kspc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_kspc_in   i_in,
    output logic       o_valid,
    output t_kspc_out  o_result,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_wdata
);

    logic           r_in_vld;
    t_kspc_in       r_in;
    logic           r_orig_pc;
    logic [1:0]     r_video;
    logic [7:0]     r_port_a;
    logic [7:0]     r_port_b;
    logic           r_blocked;
    logic           r_irq;
    logic           r_seen;
    logic           r_out_vld;
    t_kspc_out      r_out;

    logic [7:0]     n_port_a;
    logic [7:0]     n_port_b;
    logic           n_blocked;
    logic           n_irq;
    logic           n_seen;
    logic [7:0]     n_read;
    logic [7:0]     port_c;

    t_kspc_ring_ctl ring_ctl;
    t_kspc_ring_sts ring_sts;

    kspc_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .o_sts   (ring_sts)
    );

    assign o_busy   = 1'b0;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    function automatic logic [7:0] video_pick(input logic [1:0] kind,
                                              input logic [7:0] ega,
                                              input logic [7:0] mono,
                                              input logic [7:0] color);
        case (kind)
            VIDEO_EGA:  return ega;
            VIDEO_MONO: return mono;
            default:    return color;
        endcase
    endfunction

    always_comb begin
        if (r_orig_pc) begin
            port_c = r_port_b[PB_SWSEL] ? SW_C_ORIG_HI : SW_C_ORIG_LO;
        end else if (r_port_b[PB_SWHI]) begin
            port_c = video_pick(r_video, SW_C_EGA, SW_C_MONO, SW_C_CGA);
        end else begin
            port_c = SW_C_DEFAULT;
        end
        if (r_in.speaker_timer_out) begin
            port_c = port_c | TIMER_OUT_BIT;
        end
    end

    always_comb begin
        ring_ctl  = '0;
        n_port_a  = r_port_a;
        n_port_b  = r_port_b;
        n_blocked = r_blocked;
        n_irq     = r_irq;
        n_seen    = r_seen;
        n_read    = '0;
        if (r_in_vld) begin
            case (r_in.mode)
                MODE_KEY: begin
                    ring_ctl.push = 1'b1;
                    ring_ctl.data = r_in.data_byte;
                end
                MODE_TICK: begin
                    if (!ring_sts.empty && !r_blocked) begin
                        ring_ctl.pop = 1'b1;
                        n_port_a     = ring_sts.head_data;
                        n_blocked    = 1'b1;
                        n_irq        = 1'b1;
                    end
                end
                MODE_READ: begin
                    case (r_in.port_offset)
                        PORT_A: begin
                            if (r_orig_pc && r_port_b[PB_ACK]) begin
                                n_read = video_pick(r_video, SW_A_EGA, SW_A_MONO,
                                                    SW_A_CGA);
                            end else begin
                                n_read = r_port_a;
                            end
                        end
                        PORT_B:  n_read = r_port_b;
                        PORT_C:  n_read = port_c;
                        default: n_read = UNKNOWN_READ;
                    endcase
                end
                default: begin
                    if (r_in.port_offset == PORT_B) begin
                        // rising flush bit: restart ring with the self-test code
                        if (!r_port_b[PB_FLUSH] && r_in.data_byte[PB_FLUSH]) begin
                            ring_ctl.flush = 1'b1;
                            ring_ctl.data  = SELF_TEST_CODE;
                        end
                        // rising acknowledge bit: clear latch and drop irq
                        if (!r_port_b[PB_ACK] && r_in.data_byte[PB_ACK]) begin
                            n_port_a  = '0;
                            n_blocked = 1'b0;
                            n_irq     = 1'b0;
                        end
                        n_port_b = r_in.data_byte;
                        if (r_in.data_byte[PB_SPKEN]) begin
                            n_seen = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_in;
        r_out.read_data            <= n_read;
        r_out.irq_line             <= n_irq;
        r_out.speaker_gate         <= n_port_b[PB_GATE];
        r_out.spk_data_en          <= n_port_b[PB_SPKEN];
        r_out.speaker_ever_enabled <= n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_orig_pc <= 1'b0;
            r_video   <= VIDEO_CGA;
            r_port_a  <= '0;
            r_port_b  <= '0;
            r_blocked <= 1'b0;
            r_irq     <= 1'b0;
            r_seen    <= 1'b0;
        end else begin
            r_in_vld  <= i_start && !o_busy;
            r_out_vld <= r_in_vld;
            r_port_a  <= n_port_a;
            r_port_b  <= n_port_b;
            r_blocked <= n_blocked;
            r_irq     <= n_irq;
            r_seen    <= n_seen;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIG_PC: r_orig_pc <= i_cfg_wdata[0];
                    CFG_VIDEO:   r_video   <= i_cfg_wdata;
                    default:     r_video   <= r_video;
                endcase
            end
        end
    end

endmodule

>>> design/kspc_ring.sv
// ----------------------------------------------------------------------------
// kspc_ring
// Scan code ring: push at tail, pop at head, flush that restarts with one code.
// ----------------------------------------------------------------------------
module kspc_ring import kspc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_kspc_ring_ctl i_ctl,
    output t_kspc_ring_sts o_sts
);

    logic [7:0]         r_mem [RING_DEPTH];
    logic [RING_AW-1:0] r_head;
    logic [RING_AW-1:0] r_tail;
    logic [RING_CW-1:0] r_count;

    function automatic logic [RING_AW-1:0] ptr_inc(input logic [RING_AW-1:0] p);
        if (p == RING_AW'(RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == RING_CW'(RING_DEPTH));
    assign o_sts.head_data = r_mem[r_head];

    // entries hold no reset; only the pointers and count do
    always_ff @(posedge i_clk) begin
        if (i_ctl.flush) begin
            r_mem[r_head] <= i_ctl.data;
        end else if (i_ctl.push && !o_sts.full) begin
            r_mem[r_tail] <= i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_ctl.flush) begin
            // restart with a single code at the head
            r_tail  <= ptr_inc(r_head);
            r_count <= RING_CW'(1);
        end else if (i_ctl.push && !o_sts.full) begin
            r_tail  <= ptr_inc(r_tail);
            r_count <= r_count + 1'b1;
        end else if (i_ctl.pop && !o_sts.empty) begin
            r_head  <= ptr_inc(r_head);
            r_count <= r_count - 1'b1;
        end
    end

endmodule

>>> design/kspc_checker.sv
// ----------------------------------------------------------------------------
// kspc_checker
// Port-level checks for the keyboard scan port controller.
// ----------------------------------------------------------------------------
module kspc_checker import kspc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input t_kspc_in  i_in,
    input logic      o_valid,
    input t_kspc_out o_result
);

    // every taken word yields its result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_valid)
        else $error("taken word produced no result");

    // no result appears without a taken word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without a taken word");

    // only reads return data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(i_in.mode, 2) == MODE_READ || o_result.read_data == 8'h00))
        else $error("non-read word returned data");

    // enabled speaker implies the sticky flag is set
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.spk_data_en) |-> o_result.speaker_ever_enabled)
        else $error("speaker enabled without sticky flag");

endmodule

bind keyboard_scan_port_controller kspc_checker u_kspc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_in     (i_in),
    .o_valid  (o_valid),
    .o_result (o_result)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the keyboard scan port controller: a queue-fed driver sends
// scan codes, poll ticks, port reads and port writes with random gaps, a
// predictor in this file works out each result word, and a monitor checks
// every strobed result against it. Every switch and video setting is swept.
// ----------------------------------------------------------------------------
module tb_top;
    import kspc_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          IDLE_PCT     = 28;
    localparam int          PHASE_WORDS  = 230;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  PORT_NONE    = 2'd3;   // no port decoded here

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    t_kspc_in   i_in = '0;
    logic       o_valid;
    t_kspc_out  o_result;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = CFG_ORIG_PC;
    logic [1:0] i_cfg_wdata = 2'd0;

    keyboard_scan_port_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------------
    logic [7:0] ring_codes [RING_DEPTH];
    int         ring_rd;
    int         ring_wr;
    int         ring_fill;
    logic       latch_held;
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic       irq_level;
    logic       spk_seen;
    logic       orig_pc;
    logic [1:0] video;

    t_kspc_in   pending_words [$];
    t_kspc_out  expected_words [$];

    bit         sender_steady = 1'b0;
    int         cycle_count = 0;
    int         mismatch_count = 0;
    int         stray_count = 0;
    int         words_sent = 0;
    int         reads_seen = 0;
    int         codes_latched = 0;
    int         codes_dropped = 0;
    int         ring_flushes = 0;

    function automatic logic [7:0] video_pick(input logic [7:0] ega, input logic [7:0] mono,
                                              input logic [7:0] color);
        if (video == VIDEO_EGA)
            return ega;
        if (video == VIDEO_MONO)
            return mono;
        return color;
    endfunction

    function automatic void ring_add(input logic [7:0] code);
        if (ring_fill >= RING_DEPTH) begin
            codes_dropped++;
            return;
        end
        ring_codes[ring_wr] = code;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        ring_fill++;
    endfunction

    function automatic t_kspc_out port_response(input t_kspc_in w);
        t_kspc_out r;
        logic [7:0] v;
        r = '0;
        case (w.mode)
            MODE_KEY: ring_add(w.data_byte);
            MODE_TICK: begin
                if (ring_fill != 0 && !latch_held) begin
                    port_a = ring_codes[ring_rd];
                    ring_rd = (ring_rd + 1) % RING_DEPTH;
                    ring_fill--;
                    latch_held = 1'b1;
                    irq_level = 1'b1;
                    codes_latched++;
                end
            end
            MODE_READ: begin
                reads_seen++;
                case (w.port_offset)
                    PORT_A: begin
                        if (orig_pc && port_b[PB_ACK])
                            r.read_data = video_pick(SW_A_EGA, SW_A_MONO, SW_A_CGA);
                        else
                            r.read_data = port_a;
                    end
                    PORT_B: r.read_data = port_b;
                    PORT_C: begin
                        if (orig_pc)
                            v = port_b[PB_SWSEL] ? SW_C_ORIG_HI : SW_C_ORIG_LO;
                        else if (port_b[PB_SWHI])
                            v = video_pick(SW_C_EGA, SW_C_MONO, SW_C_CGA);
                        else
                            v = SW_C_DEFAULT;
                        if (w.speaker_timer_out)
                            v = v | TIMER_OUT_BIT;
                        r.read_data = v;
                    end
                    default: r.read_data = UNKNOWN_READ;
                endcase
            end
            default: begin
                if (w.port_offset == PORT_B) begin
                    if (!port_b[PB_FLUSH] && w.data_byte[PB_FLUSH]) begin
                        ring_wr = ring_rd;
                        ring_fill = 0;
                        ring_add(SELF_TEST_CODE);
                        ring_flushes++;
                    end
                    if (!port_b[PB_ACK] && w.data_byte[PB_ACK]) begin
                        port_a = '0;
                        latch_held = 1'b0;
                        irq_level = 1'b0;
                    end
                    port_b = w.data_byte;
                    if (w.data_byte[PB_SPKEN])
                        spk_seen = 1'b1;
                end
            end
        endcase
        r.irq_line             = irq_level;
        r.speaker_gate         = port_b[PB_GATE];
        r.spk_data_en          = port_b[PB_SPKEN];
        r.speaker_ever_enabled = spk_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: predict on acceptance, load the next word unless idling
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_words.push_back(port_response(i_in));
                words_sent++;
            end
            if (i_start && o_busy) begin
                // hold the word until it is taken
            end else if (pending_words.size() != 0 &&
                         (sender_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in    <= pending_words.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_kspc_out want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                stray_count++;
                if (mismatch_count + stray_count <= MAX_REPORTS)
                    $display("[%0t] result word with nothing expected: %h", $realtime, o_result);
            end else begin
                want = expected_words.pop_front();
                if (o_result.read_data !== want.read_data ||
                    o_result.irq_line !== want.irq_line ||
                    o_result.speaker_gate !== want.speaker_gate ||
                    o_result.spk_data_en !== want.spk_data_en ||
                    o_result.speaker_ever_enabled !== want.speaker_ever_enabled) begin
                    mismatch_count++;
                    if (mismatch_count + stray_count <= MAX_REPORTS)
                        $display({"[%0t] mismatch: expected rd=%h irq=%b gate=%b en=%b ",
                                  "seen=%b, got rd=%h irq=%b gate=%b en=%b seen=%b"},
                                 $realtime, want.read_data, want.irq_line, want.speaker_gate,
                                 want.spk_data_en, want.speaker_ever_enabled,
                                 o_result.read_data, o_result.irq_line, o_result.speaker_gate,
                                 o_result.spk_data_en, o_result.speaker_ever_enabled);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d words pending, %0d expected",
                     $realtime, pending_words.size(), expected_words.size());
            $display("keyboard_scan_port_controller regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic int queue_word(input logic [1:0] mode, input logic [1:0] offset,
                                      input logic [7:0] data, input logic timer);
        t_kspc_in w;
        w.mode              = mode;
        w.port_offset       = offset;
        w.data_byte         = data;
        w.speaker_timer_out = timer;
        pending_words.push_back(w);
        return 1;
    endfunction

    function automatic logic [1:0] any_offset();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic fill_random(input int count);
        int made;
        int pick;
        int k;
        int n;
        logic [7:0] d;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // key, tick, read the code, acknowledge, release
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    made += queue_word(MODE_KEY, any_offset(), any_byte(), any_bit());
                made += queue_word(MODE_TICK, any_offset(), any_byte(), any_bit());
                made += queue_word(MODE_READ, PORT_A, any_byte(), any_bit());
                if ($urandom_range(0, 2) == 0)
                    made += queue_word(MODE_READ, PORT_C, any_byte(), any_bit());
                d = any_byte();
                d[PB_ACK] = 1'b1;
                d[PB_FLUSH] = ($urandom_range(0, 7) == 0);
                made += queue_word(MODE_WRITE, PORT_B, d, any_bit());
                if ($urandom_range(0, 3) == 0)
                    made += queue_word(MODE_READ, any_offset(), any_byte(), any_bit());
                d = any_byte();
                d[PB_ACK] = 1'b0;
                d[PB_FLUSH] = 1'b0;
                made += queue_word(MODE_WRITE, PORT_B, d, any_bit());
            end else if (pick < 55) begin
                // burst of codes, often past a full ring
                n = $urandom_range(12, 20);
                for (k = 0; k < n; k++)
                    made += queue_word(MODE_KEY, any_offset(), any_byte(), any_bit());
                made += queue_word(MODE_TICK, any_offset(), any_byte(), any_bit());
            end else if (pick < 63) begin
                d = any_byte();
                d[PB_FLUSH] = 1'b1;
                made += queue_word(MODE_WRITE, PORT_B, d, any_bit());
                made += queue_word(MODE_TICK, any_offset(), any_byte(), any_bit());
                d = any_byte();
                d[PB_FLUSH] = 1'b0;
                made += queue_word(MODE_WRITE, PORT_B, d, any_bit());
            end else begin
                made += queue_word(2'($urandom_range(0, 3)), any_offset(), any_byte(),
                                   any_bit());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_start || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic pc, input logic [1:0] vk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ORIG_PC;
        i_cfg_wdata <= {1'b0, pc};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_VIDEO;
        i_cfg_wdata <= vk;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        orig_pc = pc;
        video   = vk;
    endtask

    initial begin
        int p;
        int dummy;
        ring_rd    = 0;
        ring_wr    = 0;
        ring_fill  = 0;
        latch_held = 1'b0;
        port_a     = '0;
        port_b     = '0;
        irq_level  = 1'b0;
        spk_seen   = 1'b0;
        orig_pc    = 1'b0;
        video      = VIDEO_CGA;
        for (p = 0; p < RING_DEPTH; p++)
            ring_codes[p] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset defaults, every port, ignored writes, latch and flush
        dummy = queue_word(MODE_READ, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_B, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_C, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_C, 8'hFF, 1'b1);
        dummy = queue_word(MODE_READ, PORT_NONE, 8'h00, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_A, 8'hFF, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_C, 8'hFF, 1'b1);
        dummy = queue_word(MODE_WRITE, PORT_NONE, 8'hFF, 1'b0);
        dummy = queue_word(MODE_TICK, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_KEY, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_KEY, PORT_NONE, 8'hFF, 1'b1);
        dummy = queue_word(MODE_TICK, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_TICK, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_B, 8'h80, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_B, 8'h00, 1'b0);
        dummy = queue_word(MODE_TICK, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_B, 8'h4B, 1'b0);
        dummy = queue_word(MODE_READ, PORT_C, 8'h00, 1'b1);
        dummy = queue_word(MODE_WRITE, PORT_B, 8'hC8, 1'b0);
        dummy = queue_word(MODE_TICK, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_A, 8'h00, 1'b0);
        dummy = queue_word(MODE_READ, PORT_B, 8'h00, 1'b0);
        dummy = queue_word(MODE_WRITE, PORT_B, 8'h00, 1'b0);
        wait_drained();

        // sweep every switch and video setting, extremes included
        for (p = 0; p < 8; p++) begin
            write_settings(p[2], 2'(p));
            sender_steady = (p == 3);
            fill_random(PHASE_WORDS);
            wait_drained();
        end
        sender_steady = 1'b0;

        mismatch_count += expected_words.size();
        $display("covered %0d words: %0d port reads, %0d codes latched, %0d dropped",
                 words_sent, reads_seen, codes_latched, codes_dropped);
        $display("%0d ring flushes across both switch modes and all four video kinds",
                 ring_flushes);
        if (mismatch_count == 0 && stray_count == 0) begin
            $display("keyboard_scan_port_controller regression: pass");
        end else begin
            $display("%0d mismatches, %0d unexpected result words", mismatch_count, stray_count);
            $display("keyboard_scan_port_controller regression: fail");
        end
        $finish;
    end

endmodule
